### hw/rtl/integer_to_radix_text_macros.svh
// Assertion macros used by the integer-to-radix-text top level.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define ITR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define ITR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/itr_pkg.sv
// Shared constants, types and the digit character map for integer-to-radix-text.
package itr_pkg;

  // Sizing
  localparam int MAX_DIGITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;

  // Radix limits and character codes
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;

  // Divider status back to the sequencer
  typedef struct packed {
    logic                    done;
    logic [VALUE_BITS-1:0]   quotient;
    logic [DIGIT_W-1:0]      remainder;
  } itr_div_stat_t;

  // Digit value (0..35) to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic low);
    logic [CHAR_W-1:0] ch;
    if (d < RADIX_DEC) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else if (low) begin
      ch = CHAR_LOWER_A + CHAR_W'(d - RADIX_DEC);
    end else begin
      ch = CHAR_UPPER_A + CHAR_W'(d - RADIX_DEC);
    end
    return ch;
  endfunction

endpackage

### hw/rtl/itr_div.sv
// Bit-serial restoring divider: value by radix, one quotient bit per cycle.
module itr_div import itr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIGIT_W-1:0]    divisor,
  output itr_div_stat_t         stat
);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [DIGIT_W-1:0]    div_r;
  logic [STEP_W-1:0]     step_r;
  logic                  run_r;
  logic                  done_r;
  logic [DIGIT_W:0]      trial;
  logic                  fits;

  // One restoring step: bring in next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[VALUE_BITS-1]};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? DIGIT_W'(trial - {1'b0, div_r}) : trial[DIGIT_W-1:0];
    quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(VALUE_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.done      = done_r;
  assign stat.quotient  = quo_r;
  assign stat.remainder = rem_r;

endmodule

### hw/rtl/itr_stack.sv
// Digit store: written low digit first, read back high digit first.
module itr_stack import itr_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [DIGIT_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/integer_to_radix_text.sv
// Top level: integer to ASCII digits in signed decimal or radix 2..36.
//
//   channel   handshake            payload
//   --------  -------------------  -----------------------------------------------
//   request   start & !busy        in_value, in_signed_mode, in_base,
//                                  in_lower_case, in_digit_count
//   result    out_strobe (1 cyc)   out_character, out_last
//
// Each digit takes one pass of the bit-serial divider (S_LOAD, then S_WAIT until
// done); each character is then read back (S_READ, S_EMIT), after S_SIGN puts out
// a minus sign if needed. A new request is taken only once the last one is done.
// Reset (rst_n low, synchronous) returns the sequencer to idle; no clearing pass.
// busy is high from acceptance until the last character is issued; results
// cannot be stalled and leave on a fixed schedule.
`include "integer_to_radix_text_macros.svh"

module integer_to_radix_text import itr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic        in_signed_mode,
  input  logic [5:0]  in_base,
  input  logic        in_lower_case,
  input  logic [5:0]  in_digit_count,
  output logic        out_strobe,
  output logic [6:0]  out_character,
  output logic        out_last
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0]    radix_r, radix_nxt;
  logic [CNT_W-1:0]      want_r, want_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  low_r, low_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic [VALUE_BITS-1:0] val_ext;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  more;
  logic                  div_load;
  itr_div_stat_t         div_stat;
  logic                  wr_en;
  logic                  rd_en;
  logic [DIGIT_W-1:0]    rd_data;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign val_ext = VALUE_BITS'(in_value);
  assign cnt_inc = cnt_r + CNT_W'(1);

  // Another digit after this one? Fixed count, or minimal until quotient is zero (at most MAX_DIGITS)
  assign more = (want_r != '0) ? (cnt_inc < want_r)
                               : ((div_stat.quotient != '0) &&
                                  (cnt_inc < CNT_W'(MAX_DIGITS)));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    radix_nxt      = radix_r;
    want_nxt       = want_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    low_nxt        = low_r;
    out_strobe_nxt = 1'b0;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    div_load       = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          low_nxt = in_lower_case;
          cnt_nxt = '0;
          if (32'(in_digit_count) > MAX_DIGITS) begin
            want_nxt = CNT_W'(MAX_DIGITS);
          end else begin
            want_nxt = CNT_W'(in_digit_count);
          end
          if (in_signed_mode) begin
            radix_nxt = RADIX_DEC;
            neg_nxt   = val_ext[VALUE_BITS-1];
            mag_nxt   = val_ext[VALUE_BITS-1] ? (~val_ext + VALUE_BITS'(1)) : val_ext;
          end else begin
            neg_nxt = 1'b0;
            mag_nxt = val_ext;
            priority if (in_base < RADIX_MIN) begin
              radix_nxt = RADIX_MIN;
            end else if (in_base > RADIX_MAX) begin
              radix_nxt = RADIX_MAX;
            end else begin
              radix_nxt = in_base;
            end
          end
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        div_load  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_inc;
          mag_nxt = div_stat.quotient;
          priority if (more) begin
            state_nxt = S_LOAD;
          end else if (neg_r) begin
            state_nxt = S_SIGN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SIGN: begin
        out_strobe_nxt = 1'b1;
        out_char_nxt   = CHAR_MINUS;
        out_last_nxt   = 1'b0;
        state_nxt      = S_READ;
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_char_nxt   = digit_char(rd_data, low_r);
        out_last_nxt   = (cnt_r == CNT_W'(1));
        cnt_nxt        = cnt_r - CNT_W'(1);
        state_nxt      = (cnt_r == CNT_W'(1)) ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    radix_r    <= radix_nxt;
    want_r     <= want_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    low_r      <= low_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Divider
  itr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (mag_r),
    .divisor  (radix_r),
    .stat     (div_stat)
  );

  // Digit store
  itr_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (div_stat.remainder),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(cnt_r - CNT_W'(1))),
    .rd_data (rd_data)
  );

  assign out_strobe    = out_strobe_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // Checks
  `ITR_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
  `ITR_ASSERT_NOW(a_done_in_wait, div_stat.done, state_r == S_WAIT, "divider done outside wait")
  `ITR_ASSERT_NOW(a_last_idle, out_strobe_r && out_last_r, state_r == S_IDLE, "last char not idle")

endmodule

### tb/sv/integer_to_radix_text_tb.sv
// Self-checking testbench for integer_to_radix_text: request driver, character monitor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itr_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 360;
  localparam int unsigned CYCLE_LIMIT     = 2_500_000;
  localparam int unsigned DRAIN_CYCLES    = 100;

  localparam logic MODE_SIGNED = 1'b1;
  localparam logic MODE_RADIX  = 1'b0;
  localparam logic CASE_LOWER  = 1'b1;
  localparam logic CASE_UPPER  = 1'b0;

  localparam string UPPER_DIGITS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string LOWER_DIGITS = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct {
    logic [31:0] value;
    logic        signed_mode;
    logic [5:0]  base;
    logic        lower_case;
    logic [5:0]  digit_count;
  } text_req_t;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_value = '0;
  logic        in_signed_mode = 1'b0;
  logic [5:0]  in_base = '0;
  logic        in_lower_case = 1'b0;
  logic [5:0]  in_digit_count = '0;
  logic        out_strobe;
  logic [6:0]  out_character;
  logic        out_last;

  text_req_t   pending_reqs[$];
  text_char_t  expected_chars[$];
  text_req_t   active_req;
  int unsigned total_reqs = 0;
  int unsigned accepted_reqs = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;

  integer_to_radix_text dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_signed_mode (in_signed_mode),
    .in_base        (in_base),
    .in_lower_case  (in_lower_case),
    .in_digit_count (in_digit_count),
    .out_strobe     (out_strobe),
    .out_character  (out_character),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected text for one request, appended to the character queue
  function automatic void predict_text(input text_req_t req);
    logic [VALUE_BITS-1:0] mag;
    logic [31:0]           radix;
    int unsigned           want;
    bit                    negative;
    string                 digit_set;
    byte                   digits[$];
    text_char_t            ch;
    mag       = req.value;
    radix     = req.base;
    want      = req.digit_count;
    negative  = 1'b0;
    digit_set = req.lower_case ? LOWER_DIGITS : UPPER_DIGITS;
    if (radix < RADIX_MIN) radix = RADIX_MIN;
    if (radix > RADIX_MAX) radix = RADIX_MAX;
    // signed mode: decimal magnitude, most negative wraps to 2^31 unsigned
    if (req.signed_mode) begin
      radix = RADIX_DEC;
      if (mag[VALUE_BITS-1]) begin
        negative = 1'b1;
        mag = ~mag + 1'b1;
      end
    end
    if (want > MAX_DIGITS) want = MAX_DIGITS;
    // digits collected least significant first
    if (want != 0) begin
      for (int unsigned i = 0; i < want; i++) begin
        digits.push_back(digit_set[int'(mag % radix)]);
        mag = mag / radix;
      end
    end else begin
      if (mag == 0) digits.push_back(digit_set[0]);
      while (mag != 0 && digits.size() < MAX_DIGITS) begin
        digits.push_back(digit_set[int'(mag % radix)]);
        mag = mag / radix;
      end
    end
    if (negative) begin
      ch.character = CHAR_MINUS;
      ch.last      = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      ch.character = digits[i][CHAR_W-1:0];
      ch.last      = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void add_request(input logic [31:0] value, input logic signed_mode,
                                      input logic [5:0] base, input logic lower_case,
                                      input logic [5:0] digit_count);
    text_req_t req;
    req.value       = value;
    req.signed_mode = signed_mode;
    req.base        = base;
    req.lower_case  = lower_case;
    req.digit_count = digit_count;
    pending_reqs.push_back(req);
    total_reqs++;
  endfunction

  // Mostly no gap, some short ones, a few long stretches
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Values of assorted bit lengths so short and long texts both show up
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    int unsigned nbits;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    v    = $urandom;
    if (roll < 30) return v;
    if (roll < 40) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0000;
        4: return 32'h7FFF_FFFF;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    nbits = $urandom_range(1, 31);
    v = v & ((32'h1 << nbits) - 1);
    // negative numbers near zero for signed mode
    if ($urandom_range(0, 3) == 0) v = ~v;
    return v;
  endfunction

  function automatic void add_random_request();
    logic [5:0]  base;
    logic [5:0]  count;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) base = 6'($urandom_range(RADIX_MIN, RADIX_MAX));
    else base = 6'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < 50) count = '0;
    else if (roll < 85) count = 6'($urandom_range(1, 12));
    else if (roll < 93) count = 6'($urandom_range(13, MAX_DIGITS));
    else count = 6'($urandom_range(0, 63));
    add_request(pick_value(), 1'($urandom_range(0, 1)), base, 1'($urandom_range(0, 1)), count);
  endfunction

  // Stimulus, reset and end of run
  initial begin
    // directed: edges of each field and the saturating cases
    add_request(32'h0000_0000, MODE_SIGNED, 6'd10, CASE_UPPER, 6'd0);
    add_request(32'h7FFF_FFFF, MODE_SIGNED, 6'd10, CASE_UPPER, 6'd0);
    add_request(32'h8000_0000, MODE_SIGNED, 6'd16, CASE_UPPER, 6'd0);
    add_request(32'hFFFF_FFFF, MODE_SIGNED, 6'd2,  CASE_LOWER, 6'd0);
    add_request(32'hFFFF_FF85, MODE_SIGNED, 6'd10, CASE_UPPER, 6'd2);
    add_request(32'hFFFF_FF85, MODE_SIGNED, 6'd36, CASE_LOWER, 6'd12);
    add_request(32'h8000_0000, MODE_SIGNED, 6'd0,  CASE_UPPER, 6'd63);
    add_request(32'hFFFF_FFFF, MODE_RADIX,  6'd2,  CASE_UPPER, 6'd0);
    add_request(32'hFFFF_FFFF, MODE_RADIX,  6'd36, CASE_UPPER, 6'd0);
    add_request(32'hFFFF_FFFF, MODE_RADIX,  6'd36, CASE_LOWER, 6'd0);
    add_request(32'hDEAD_BEEF, MODE_RADIX,  6'd16, CASE_UPPER, 6'd0);
    add_request(32'hDEAD_BEEF, MODE_RADIX,  6'd16, CASE_LOWER, 6'd0);
    add_request(32'h0000_00A5, MODE_RADIX,  6'd0,  CASE_UPPER, 6'd0);
    add_request(32'h0000_00A5, MODE_RADIX,  6'd1,  CASE_UPPER, 6'd0);
    add_request(32'h1234_5678, MODE_RADIX,  6'd63, CASE_LOWER, 6'd0);
    add_request(32'h1234_5678, MODE_RADIX,  6'd37, CASE_UPPER, 6'd0);
    add_request(32'h0000_0023, MODE_RADIX,  6'd36, CASE_UPPER, 6'd1);
    add_request(32'h0000_0000, MODE_RADIX,  6'd8,  CASE_UPPER, 6'd0);
    add_request(32'h0000_0000, MODE_RADIX,  6'd8,  CASE_UPPER, 6'd5);
    add_request(32'hFFFF_FFFF, MODE_RADIX,  6'd10, CASE_UPPER, 6'd32);
    add_request(32'h0000_0007, MODE_RADIX,  6'd2,  CASE_UPPER, 6'd33);
    add_request(32'h5555_5555, MODE_RADIX,  6'd2,  CASE_LOWER, 6'd63);
    add_request(32'h0000_0001, MODE_RADIX,  6'd3,  CASE_UPPER, 6'd0);
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) add_random_request();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (!(accepted_reqs == total_reqs && expected_chars.size() == 0)) @(posedge clk);
    // catch stray characters after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Request driver: start is held until busy lets the request in
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      hold_cycles = pick_gap();
    end else begin
      if (start && !busy) begin
        predict_text(active_req);
        accepted_reqs++;
        hold_cycles = pick_gap();
      end
      if (start && busy) begin
        // request still waiting
      end else if (hold_cycles != 0) begin
        hold_cycles--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        active_req = pending_reqs.pop_front();
        in_value       <= active_req.value;
        in_signed_mode <= active_req.signed_mode;
        in_base        <= active_req.base;
        in_lower_case  <= active_req.lower_case;
        in_digit_count <= active_req.digit_count;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Character monitor: every strobe is compared with the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_strobe) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char 0x%02h last %0b",
                 $time, out_character, out_last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_character !== want.character) begin
          $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                   $time, want.character, out_character);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule
